// ===== rtl/clipped_color_key_blit_macros.svh =====
// Assertion macros shared by the blit RTL.
`ifndef CLIPPED_COLOR_KEY_BLIT_MACROS_SVH
`define CLIPPED_COLOR_KEY_BLIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCKB_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("blit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCKB_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("blit assertion failed");

`endif

// ===== rtl/cckb_pkg.sv =====
// Types and constants of the clipped color-key blit.
`timescale 1ns / 1ps

package cckb_pkg;

    // Largest source image dimension; sets the position counter width.
    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);

    // Field widths.
    localparam int DIM_W    = 13;
    localparam int PITCH_W  = 15;
    localparam int PIXEL_W  = 32;
    localparam int OFFSET_W = 26;
    localparam int BPP_SH   = 2;

    // Screen position width, signed, with room for the sum of offset and counter.
    localparam int SX_W  = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 2;
    // Width used to compare the next column against the wrap bounds.
    localparam int CMP_W = ((CNT_W + 1) > DIM_W) ? (CNT_W + 1) : DIM_W;
    // Width of the row times pitch product.
    localparam int PROD_W = DIM_W + PITCH_W;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    // Configuration port.
    localparam int ADDR_W  = 5;
    localparam int APB_W   = 32;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_LINE_PITCH    = 3'd2,
        REG_IMAGE_X       = 3'd3,
        REG_IMAGE_Y       = 3'd4,
        REG_IMAGE_WIDTH   = 3'd5,
        REG_COLOR_KEY     = 3'd6,
        REG_KEY_ENABLE    = 3'd7
    } t_reg_idx;

    // Reset values of the registers.
    localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [PITCH_W-1:0] RST_LINE_PITCH    = 15'd2560;
    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH   = 13'd1;

endpackage

// ===== rtl/clipped_color_key_blit.sv =====
// Clipped color-key blit: source pixels in, destination offsets and colors out.
`timescale 1ns / 1ps
`include "clipped_color_key_blit_macros.svh"

//  Channel   | Direction | Handshake            | Contents
//  s_axis    | in        | tvalid/tready        | tdata: pixel; tlast: last pixel
//  m_axis    | out       | tvalid/tready        | tdata: byte offset, color
//  apb       | in/out    | psel/penable/pready  | eight registers at 4*i
//
// One word is accepted per cycle when the output side keeps up.
// An accepted word passes through two registers on its way to m_axis: the first holds the
// clip and key decision, the second the offset from the row-by-pitch multiply.
// Clipped and keyed words produce nothing and leave no bubble.
// Synchronous active-low reset restores register defaults and clears the counters.
// A stall on m_axis fills the two stages and then drops s_axis_tready.

module clipped_color_key_blit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Source stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cckb_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [31:0] pixel
    input  logic                                s_axis_tlast,   // last pixel of image
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cckb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [25:0] byte_offset,
                                                                // [57:26] color, rest 0
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cckb_pkg::ADDR_W-1:0]         paddr,
    input  logic [cckb_pkg::APB_W-1:0]          pwdata,
    output logic [cckb_pkg::APB_W-1:0]          prdata,
    output logic                                pready
);
    import cckb_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]        r_screen_width;
    logic [DIM_W-1:0]        r_screen_height;
    logic [PITCH_W-1:0]      r_line_pitch;
    logic signed [DIM_W-1:0] r_image_x;
    logic signed [DIM_W-1:0] r_image_y;
    logic [DIM_W-1:0]        r_image_width;
    logic [PIXEL_W-1:0]      r_color_key;
    logic                    r_key_enable;

    // Source position counters.
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;

    // Decision stage.
    logic               r_s1_valid;
    logic [DIM_W-1:0]   r_s1_sx;
    logic [DIM_W-1:0]   r_s1_sy;
    logic [PIXEL_W-1:0] r_s1_pixel;

    // Output stage.
    logic                r_out_valid;
    logic [OFFSET_W-1:0] r_out_offset;
    logic [PIXEL_W-1:0]  r_out_color;

    logic                  w_in_fire;
    logic                  w_s1_adv;
    logic                  w_cfg_wr;
    t_reg_idx              w_idx;
    logic signed [SX_W-1:0] w_sx;
    logic signed [SX_W-1:0] w_sy;
    logic                  w_inside;
    logic                  w_keyed;
    logic [CMP_W-1:0]      w_next_col;
    logic                  w_wrap;
    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W-1:0]     w_offset;

    // Handshakes: stage 1 moves on when the output register is free or draining.
    assign w_in_fire     = s_axis_tvalid & s_axis_tready;
    assign w_s1_adv      = r_s1_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_s1_valid | w_s1_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - OFFSET_W - PIXEL_W){1'b0}}, r_out_color,
                            r_out_offset};

    // Configuration port decode.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign w_idx    = t_reg_idx'(paddr[IDX_W+1:2]);

    always_comb begin
        case (w_idx)
            REG_SCREEN_WIDTH:  prdata = APB_W'(r_screen_width);
            REG_SCREEN_HEIGHT: prdata = APB_W'(r_screen_height);
            REG_LINE_PITCH:    prdata = APB_W'(r_line_pitch);
            REG_IMAGE_X:       prdata = APB_W'(r_image_x);
            REG_IMAGE_Y:       prdata = APB_W'(r_image_y);
            REG_IMAGE_WIDTH:   prdata = APB_W'(r_image_width);
            REG_COLOR_KEY:     prdata = APB_W'(r_color_key);
            REG_KEY_ENABLE:    prdata = APB_W'(r_key_enable);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_line_pitch    <= RST_LINE_PITCH;
            r_image_x       <= '0;
            r_image_y       <= '0;
            r_image_width   <= RST_IMAGE_WIDTH;
            r_color_key     <= '0;
            r_key_enable    <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: r_screen_height <= pwdata[DIM_W-1:0];
                REG_LINE_PITCH:    r_line_pitch    <= pwdata[PITCH_W-1:0];
                REG_IMAGE_X:       r_image_x       <= signed'(pwdata[DIM_W-1:0]);
                REG_IMAGE_Y:       r_image_y       <= signed'(pwdata[DIM_W-1:0]);
                REG_IMAGE_WIDTH:   r_image_width   <= pwdata[DIM_W-1:0];
                REG_COLOR_KEY:     r_color_key     <= pwdata[PIXEL_W-1:0];
                REG_KEY_ENABLE:    r_key_enable    <= pwdata[0];
                default:           r_key_enable    <= r_key_enable;
            endcase
        end
    end

    // Screen position of the incoming word and the clip and key decision.
    assign w_sx = SX_W'(r_image_x) + SX_W'(signed'({1'b0, r_col}));
    assign w_sy = SX_W'(r_image_y) + SX_W'(signed'({1'b0, r_row}));
    assign w_inside = ~w_sx[SX_W-1] && (unsigned'(w_sx) < SX_W'(r_screen_width)) &&
                      ~w_sy[SX_W-1] && (unsigned'(w_sy) < SX_W'(r_screen_height));
    assign w_keyed  = r_key_enable && (s_axis_tdata[PIXEL_W-1:0] == r_color_key);

    // Next source position: wrap at the image width or the counter limit; a last word returns to the origin.
    assign w_next_col = CMP_W'(r_col) + CMP_W'(1);
    assign w_wrap     = (w_next_col >= CMP_W'(r_image_width)) ||
                        (w_next_col >= CMP_W'(MAX_DIM));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (s_axis_tlast) begin
            n_col = '0;
            n_row = '0;
        end else if (w_wrap) begin
            n_col = '0;
            n_row = (r_row == CNT_W'(MAX_DIM - 1)) ? '0 : r_row + CNT_W'(1);
        end else begin
            n_col = w_next_col[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Decision register: only words that will be written are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= w_inside & ~w_keyed;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_sx    <= w_sx[DIM_W-1:0];
            r_s1_sy    <= w_sy[DIM_W-1:0];
            r_s1_pixel <= s_axis_tdata[PIXEL_W-1:0];
        end
    end

    // Byte offset: row times pitch plus column times four, kept modulo the field width.
    assign w_prod   = PROD_W'(r_s1_sy) * PROD_W'(r_line_pitch);
    assign w_offset = w_prod + PROD_W'({r_s1_sx, {BPP_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_offset <= w_offset[OFFSET_W-1:0];
            r_out_color  <= r_s1_pixel;
        end
    end

    // A last word always returns the position to the image origin.
    `CCKB_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_in_fire && s_axis_tlast,
        r_col == '0 && r_row == '0)
    // A keyed word never reaches the decision register.
    `CCKB_ASSERT_NEXT(a_keyed_dropped, i_clk, i_rst_n, w_in_fire && w_keyed, !r_s1_valid)
    // Back pressure on the input only comes from a full decision stage behind a stalled output register.
    `CCKB_ASSERT_NOW(a_ready_src, i_clk, i_rst_n, !s_axis_tready,
        r_s1_valid && r_out_valid && !m_axis_tready)
    // A word inside the screen with keying off is always kept.
    `CCKB_ASSERT_NEXT(a_inside_kept, i_clk, i_rst_n, w_in_fire && w_inside && !r_key_enable,
        r_s1_valid)

endmodule
